/* rtl/acf_pkg.sv */
// Shared types, constants and codes for the audio crystalizer filter.
package acf_pkg;

   localparam int CHANNELS   = 8;
   localparam int CH_W       = 3;
   localparam int HIST_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int SAMPLE_W   = 16;
   localparam int K_W        = 17;
   localparam int OUT_W      = 21;

   // Multiplier: 22-bit difference times 17-bit intensity.
   localparam int MUL_A_W = OUT_W + 1;
   localparam int PROD_W  = MUL_A_W + K_W;
   localparam int NUM_W   = PROD_W + 1;
   localparam int RES_W   = 38;

   // Divider: dividend below 2^36, divisor 4097..45056.
   localparam int DVD_W     = 36;
   localparam int DEN_W     = 16;
   localparam int DIV_STEPS = DVD_W / 2;
   localparam int CNT_W     = $clog2(DIV_STEPS);

   localparam int K_MAX   = 40960;
   localparam int K_MIN   = -40960;
   localparam int K_RESET = 8192;
   localparam int Q_MAX   = 1048575;
   localparam int Q_MIN   = -1048576;
   localparam int ONE_Q15 = 32768;
   localparam int K_ONE   = 4096;
   localparam int RND_HALF = 2048;
   localparam int RND_SHIFT = 12;

   typedef enum logic {
      CSR_INTENSITY = 1'b0,
      CSR_CLIP      = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_MUL,
      S_PREP,
      S_DIV,
      S_DONE
   } state_type;

   typedef struct packed {
      logic capture;
      logic mul;
      logic prep;
      logic div_step;
      logic finish;
   } ctrl_cmd_type;

   typedef struct packed {
      logic smooth;
   } dp_status_type;

endpackage

/* rtl/acf_req_if.sv */
// Request channel: one audio sample beat with its channel number.
interface acf_req_if;
   import acf_pkg::*;
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] sample;
   logic [CH_W-1:0]            channel;

   modport source (output valid, output sample, output channel, input ready);
   modport sink   (input valid, input sample, input channel, output ready);
endinterface

/* rtl/acf_rsp_if.sv */
// Response channel: one filtered sample beat with its channel number.
interface acf_rsp_if;
   import acf_pkg::*;
   logic                    valid;
   logic                    ready;
   logic signed [OUT_W-1:0] filtered;
   logic [CH_W-1:0]         out_channel;

   modport source (output valid, output filtered, output out_channel, input ready);
   modport sink   (input valid, input filtered, input out_channel, output ready);
endinterface

/* rtl/audio_crystalizer_filter_unit.sv */
// A request beat is captured, multiplied and prepared; when smoothing it then passes
// through the divider, which retires 2 quotient bits per cycle. One beat is processed
// at a time: the next beat is accepted only after the last one has finished.
// A finished response waits in an output register while the next beat is accepted.
// Reset (synchronous, active high) clears channel history to zero, intensity to 2.0
// and clip enable to 1, and empties the response register.
module audio_crystalizer_filter_unit
   import acf_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   acf_req_if.sink        req_chan,
   acf_rsp_if.source      rsp_chan,
   input  logic           csr_wr_en,
   input  logic           csr_index,
   input  logic [K_W-1:0] csr_wdata
);

   ctrl_cmd_type          cmd;
   dp_status_type         status;
   logic signed [K_W-1:0] intensity;
   logic                  clip_enable;

   // Hold configuration; intensity writes clamp to [-10, 10].
   acf_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .intensity   (intensity),
      .clip_enable (clip_enable)
   );

   // Sequence one beat at a time; advance to idle once the result register is free.
   acf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Multiply, divide, saturate and update the per-channel history.
   acf_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .sample      (req_chan.sample),
      .channel     (req_chan.channel),
      .intensity   (intensity),
      .clip_enable (clip_enable),
      .filtered    (rsp_chan.filtered),
      .out_channel (rsp_chan.out_channel)
   );

endmodule

/* rtl/acf_csr.sv */
// Configuration registers: clamped intensity and clip enable.
module acf_csr
   import acf_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic                  csr_index,
   input  logic [K_W-1:0]        csr_wdata,
   output logic signed [K_W-1:0] intensity,
   output logic                  clip_enable
);

   logic signed [K_W-1:0] intensity_ff, intensity_in;
   logic                  clip_ff, clip_in;
   logic signed [K_W-1:0] wdata_s;

   always_comb begin
      wdata_s      = $signed(csr_wdata);
      intensity_in = intensity_ff;
      clip_in      = clip_ff;
      if (csr_wr_en && csr_index == CSR_INTENSITY) begin
         if (wdata_s < K_W'(K_MIN)) begin
            intensity_in = K_W'(K_MIN);
         end else if (wdata_s > K_W'(K_MAX)) begin
            intensity_in = K_W'(K_MAX);
         end else begin
            intensity_in = wdata_s;
         end
      end
      if (csr_wr_en && csr_index == CSR_CLIP) begin
         clip_in = csr_wdata[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         intensity_ff <= K_W'(K_RESET);
         clip_ff      <= 1'b1;
      end else begin
         intensity_ff <= intensity_in;
         clip_ff      <= clip_in;
      end
   end

   assign intensity   = intensity_ff;
   assign clip_enable = clip_ff;

endmodule

/* rtl/acf_dp.sv */
// Datapath: channel history, shared multiplier, radix-4 divider, saturation.
module acf_dp
   import acf_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  ctrl_cmd_type               cmd,
   output dp_status_type              status,
   input  logic signed [SAMPLE_W-1:0] sample,
   input  logic [CH_W-1:0]            channel,
   input  logic signed [K_W-1:0]      intensity,
   input  logic                       clip_enable,
   output logic signed [OUT_W-1:0]    filtered,
   output logic [CH_W-1:0]            out_channel
);

   logic signed [OUT_W-1:0]    hist_ff [CHANNELS];
   logic signed [OUT_W-1:0]    hist_in [CHANNELS];
   logic signed [SAMPLE_W-1:0] v_ff, v_in;
   logic [CH_W-1:0]            ch_ff, ch_in;
   logic signed [OUT_W-1:0]    prev_ff, prev_in;
   logic                       hv_ff, hv_in;
   logic                       smooth_ff, smooth_in;
   logic signed [PROD_W-1:0]   prod_ff, prod_in;
   logic signed [RES_W-1:0]    res_ff, res_in;
   logic                       neg_ff, neg_in;
   logic [DVD_W-1:0]           dvd_ff, dvd_in;
   logic [DEN_W-1:0]           rem_ff, rem_in;
   logic [DEN_W-1:0]           den_ff, den_in;
   logic signed [OUT_W-1:0]    filt_ff, filt_in;
   logic [CH_W-1:0]            och_ff, och_in;

   logic                       in_range;
   logic [HIST_IDX_W-1:0]      idx_in, idx_ff;
   logic signed [MUL_A_W-1:0]  mul_a;
   logic signed [NUM_W-1:0]    rnd_sum;
   logic signed [NUM_W-1:0]    num;
   logic [NUM_W-1:0]           mag;
   logic signed [K_W:0]        den_full;
   logic [DEN_W:0]             r1, r2;
   logic                       ge1, ge2;
   logic [DEN_W-1:0]           r1s;
   logic [DVD_W-1:0]           dvd1;
   logic signed [RES_W-1:0]    y_pre, y_sat, y_clip;

   assign in_range = (32'(channel) < CHANNELS);
   assign idx_in   = channel[HIST_IDX_W-1:0];
   assign idx_ff   = ch_ff[HIST_IDX_W-1:0];

   always_comb begin
      // operands and arithmetic
      mul_a = smooth_ff ? MUL_A_W'(prev_ff) : (MUL_A_W'(v_ff) - MUL_A_W'(prev_ff));
      rnd_sum  = NUM_W'(prod_ff) + NUM_W'(RND_HALF);
      num      = (NUM_W'(v_ff) <<< RND_SHIFT) - NUM_W'(prod_ff);
      mag      = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
      den_full = (K_W+1)'(K_ONE) - (K_W+1)'(intensity);

      // two restoring steps per cycle
      r1   = {rem_ff, dvd_ff[DVD_W-1]};
      ge1  = (r1 >= {1'b0, den_ff});
      r1s  = ge1 ? DEN_W'(r1 - {1'b0, den_ff}) : r1[DEN_W-1:0];
      dvd1 = {dvd_ff[DVD_W-2:0], ge1};
      r2   = {r1s, dvd1[DVD_W-1]};
      ge2  = (r2 >= {1'b0, den_ff});

      // result select, saturate, clip
      if (smooth_ff) begin
         y_pre = neg_ff ? -RES_W'(dvd_ff) : RES_W'(dvd_ff);
      end else begin
         y_pre = res_ff;
      end
      if (y_pre > RES_W'(Q_MAX)) begin
         y_sat = RES_W'(Q_MAX);
      end else if (y_pre < RES_W'(Q_MIN)) begin
         y_sat = RES_W'(Q_MIN);
      end else begin
         y_sat = y_pre;
      end
      if (clip_enable && y_sat > RES_W'(ONE_Q15)) begin
         y_clip = RES_W'(ONE_Q15);
      end else if (clip_enable && y_sat < -RES_W'(ONE_Q15)) begin
         y_clip = -RES_W'(ONE_Q15);
      end else begin
         y_clip = y_sat;
      end
   end

   always_comb begin
      hist_in   = hist_ff;
      v_in      = v_ff;
      ch_in     = ch_ff;
      prev_in   = prev_ff;
      hv_in     = hv_ff;
      smooth_in = smooth_ff;
      prod_in   = prod_ff;
      res_in    = res_ff;
      neg_in    = neg_ff;
      dvd_in    = dvd_ff;
      rem_in    = rem_ff;
      den_in    = den_ff;
      filt_in   = filt_ff;
      och_in    = och_ff;

      if (cmd.capture) begin
         v_in      = sample;
         ch_in     = channel;
         hv_in     = in_range;
         prev_in   = in_range ? hist_ff[idx_in] : '0;
         smooth_in = intensity[K_W-1];
      end
      if (cmd.mul) begin
         prod_in = PROD_W'(mul_a) * PROD_W'(intensity);
      end
      if (cmd.prep) begin
         // arithmetic shift of the rounded product: keep its sign
         res_in = RES_W'(v_ff) + RES_W'($signed(rnd_sum[NUM_W-1:RND_SHIFT]));
         neg_in = num[NUM_W-1];
         dvd_in = DVD_W'(mag + NUM_W'(den_full[DEN_W-1:1]));
         rem_in = '0;
         den_in = den_full[DEN_W-1:0];
      end
      if (cmd.div_step) begin
         rem_in = ge2 ? DEN_W'(r2 - {1'b0, den_ff}) : r2[DEN_W-1:0];
         dvd_in = {dvd1[DVD_W-2:0], ge2};
      end
      if (cmd.finish) begin
         filt_in = y_clip[OUT_W-1:0];
         och_in  = ch_ff;
         if (hv_ff) begin
            hist_in[idx_ff] = smooth_ff ? y_clip[OUT_W-1:0] : OUT_W'(v_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHANNELS; i++) begin
            hist_ff[i] <= '0;
         end
      end else begin
         hist_ff <= hist_in;
      end
   end

   always_ff @(posedge clock) begin
      v_ff      <= v_in;
      ch_ff     <= ch_in;
      prev_ff   <= prev_in;
      hv_ff     <= hv_in;
      smooth_ff <= smooth_in;
      prod_ff   <= prod_in;
      res_ff    <= res_in;
      neg_ff    <= neg_in;
      dvd_ff    <= dvd_in;
      rem_ff    <= rem_in;
      den_ff    <= den_in;
      filt_ff   <= filt_in;
      och_ff    <= och_in;
   end

   assign status.smooth = smooth_ff;
   assign filtered      = filt_ff;
   assign out_channel   = och_ff;

endmodule

/* rtl/acf_ctrl.sv */
// Controller: sequences capture, multiply, divide and result hand-off.
module acf_ctrl
   import acf_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   input  dp_status_type status,
   output ctrl_cmd_type  cmd
);

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             out_valid_ff, out_valid_in;
   logic             out_free;

   assign out_free = !out_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_MUL;
            end
         end
         S_MUL:  state_in = S_PREP;
         S_PREP: state_in = status.smooth ? S_DIV : S_DONE;
         S_DIV: begin
            if (cnt_ff == CNT_W'(DIV_STEPS - 1)) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      req_ready    = 1'b0;
      cmd          = '0;
      cnt_in       = cnt_ff;
      case (state_ff)
         S_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         S_MUL:  cmd.mul = 1'b1;
         S_PREP: begin
            cmd.prep = 1'b1;
            cnt_in   = '0;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
         end
         S_DONE: cmd.finish = out_free;
         default: cmd = '0;
      endcase
      if (cmd.finish) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_valid = out_valid_ff;

   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> state_ff == S_IDLE)
      else $error("request taken outside idle");

   a_finish_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> out_valid_ff)
      else $error("finished result not presented");

   a_sharpen_skip: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_PREP && !status.smooth) |=> state_ff == S_DONE)
      else $error("sharpen path entered divider");

   a_div_count: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DIV |-> cnt_ff < CNT_W'(DIV_STEPS))
      else $error("divider step count overrun");

endmodule
